/* sv/assert_macros.svh */
// Assertion helpers shared by the parser modules.
// Every check is clocked on the rising edge and is off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// If the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rclfp_pkg.sv */
`timescale 1ns / 1ps
package rclfp_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned CH_RAW_W   = 11;
  localparam int unsigned CH_W       = 12;
  localparam int unsigned RAW_BITS   = CHANNELS * CH_RAW_W;
  // Frame bytes 0..13 are all the unpacking and header checks ever look at.
  localparam int unsigned SHADOW_BYTES = 14;
  localparam int unsigned PAYLOAD_FIRST = 3;
  localparam int unsigned TOT_W      = 9;
  localparam int unsigned IN_W       = 40;
  localparam int unsigned OUT_W      = 136;
  localparam int unsigned PADDR_W    = 4;

  localparam logic [7:0]  CRC_POLY   = 8'hD5;
  localparam logic [15:0] SCALE_MUL  = 16'd40945;
  localparam logic [CH_W-1:0] SCALE_OFF = 12'd881;

  localparam logic [15:0] TIMEOUT_RST = 16'd1750;
  localparam logic [7:0]  ADDRESS_RST = 8'hC8;
  localparam logic [7:0]  TYPE_RST    = 8'h16;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ADDRESS = 2'd1;
  localparam logic [1:0] REG_TYPE    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_OTHER   = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [7:0]  address;
    logic [7:0]  frame_type;
  } cfg_t;

  typedef struct packed {
    status_e             status;
    logic [31:0]         time_us;
    logic [RAW_BITS-1:0] raw;
  } mid_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // raw * 40945 / 65536 + 881, a fixed-point form of raw * 0.6248 + 881.
  function automatic logic [CH_W-1:0] scale_channel(input logic [CH_RAW_W-1:0] raw);
    logic [26:0] p;
    p = 27'(raw) * 27'(SCALE_MUL);
    return {1'b0, p[26:16]} + SCALE_OFF;
  endfunction

endpackage

/* sv/rclfp_cfg_regs.sv */
`timescale 1ns / 1ps
module rclfp_cfg_regs
  import rclfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us <= TIMEOUT_RST;
      cfg_q.address    <= ADDRESS_RST;
      cfg_q.frame_type <= TYPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TIMEOUT: cfg_q.timeout_us <= pwdata[15:0];
        REG_ADDRESS: cfg_q.address    <= pwdata[7:0];
        REG_TYPE:    cfg_q.frame_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_us};
      REG_ADDRESS: prdata = {24'd0, cfg_q.address};
      REG_TYPE:    prdata = {24'd0, cfg_q.frame_type};
      default:     prdata = '0;
    endcase
  end

endmodule

/* sv/rclfp_byte_stage.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rclfp_byte_stage
  import rclfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [7:0]  s_byte_i,
  input  logic [31:0] s_time_i,
  output logic        mid_valid_o,
  input  logic        mid_ready_i,
  output mid_t        mid_o
);

  localparam int unsigned WpW = $clog2(BUFFER_BYTES + 1);

  // Input register.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] in_time_q;

  // Frame state.
  logic [WpW-1:0] wp_q, wp_d;
  logic [31:0]    start_q, start_d;
  logic [7:0]     crc_q, crc_d;
  logic [7:0]     buf_q [SHADOW_BYTES];

  // Result register.
  logic mid_valid_q, mid_valid_d;
  mid_t mid_q, mid_d;

  logic                proc_fire;
  logic [31:0]         elapsed;
  logic                restart;
  logic [WpW-1:0]      wp_eff;
  logic [TOT_W-1:0]    wp_ext;
  logic [TOT_W-1:0]    total;
  logic                drop;
  logic                done;
  logic [7:0]          type_byte;
  logic [7:0]          crc_ref;
  logic [RAW_BITS-1:0] payload;

  assign proc_fire   = in_valid_q && (!mid_valid_q || mid_ready_i);
  assign s_ready_o   = !in_valid_q || proc_fire;
  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;

  always_comb begin
    elapsed   = in_time_q - start_q;
    restart   = elapsed > {16'd0, cfg_i.timeout_us};
    wp_eff    = restart ? '0 : wp_q;
    wp_ext    = TOT_W'(wp_eff);
    drop      = wp_eff >= WpW'(BUFFER_BYTES);
    total     = {1'b0, buf_q[1]} + TOT_W'(2);
    type_byte = (wp_eff == WpW'(2)) ? in_byte_q : buf_q[2];
    // With a zero length byte the check byte is the length byte itself.
    crc_ref   = (total == TOT_W'(2)) ? buf_q[1] : in_byte_q;

    wp_d    = wp_q;
    start_d = start_q;
    crc_d   = crc_q;
    done    = 1'b0;
    if (proc_fire) begin
      if (wp_eff == '0) begin
        start_d = in_time_q;
      end
      if (!drop) begin
        wp_d = wp_eff + 1'b1;
        if (wp_eff >= WpW'(2)) begin
          if (wp_eff == WpW'(2)) begin
            crc_d = crc8_update(8'h00, in_byte_q);
          end else if (wp_ext + TOT_W'(2) <= total) begin
            crc_d = crc8_update(crc_q, in_byte_q);
          end
          if (wp_ext + TOT_W'(1) >= total) begin
            done = 1'b1;
            wp_d = '0;
          end
        end
      end
    end

    // Payload view with the byte being written forwarded in.
    for (int i = 0; i < SHADOW_BYTES - PAYLOAD_FIRST; i++) begin
      payload[i*8 +: 8] = (wp_eff == WpW'(i + PAYLOAD_FIRST)) ? in_byte_q
                                                              : buf_q[i + PAYLOAD_FIRST];
    end

    mid_d.time_us = in_time_q;
    mid_d.raw     = payload;
    if (crc_d != crc_ref) begin
      mid_d.status = ST_CRC_BAD;
    end else if (buf_q[0] == cfg_i.address && type_byte == cfg_i.frame_type) begin
      mid_d.status = ST_OK;
    end else begin
      mid_d.status = ST_OTHER;
    end

    if (proc_fire) begin
      mid_valid_d = done;
    end else begin
      mid_valid_d = mid_valid_q && !mid_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      wp_q        <= '0;
      start_q     <= '0;
      crc_q       <= '0;
      mid_valid_q <= 1'b0;
    end else begin
      if (s_ready_o) begin
        in_valid_q <= s_valid_i;
      end
      wp_q        <= wp_d;
      start_q     <= start_d;
      crc_q       <= crc_d;
      mid_valid_q <= mid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_byte_q <= s_byte_i;
      in_time_q <= s_time_i;
    end
    if (proc_fire && done) begin
      mid_q <= mid_d;
    end
    if (proc_fire && !drop) begin
      for (int i = 0; i < SHADOW_BYTES; i++) begin
        if (wp_eff == WpW'(i)) begin
          buf_q[i] <= in_byte_q;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_wp_bound, clk_i, rst_ni, wp_q <= WpW'(BUFFER_BYTES), "write position past buffer")
  `ASSERT_NEXT(a_done_rewinds, clk_i, rst_ni, proc_fire && done, wp_q == '0 && mid_valid_q, "completed frame did not restart framing")
  `ASSERT_NEXT(a_mid_holds, clk_i, rst_ni, mid_valid_q && !mid_ready_i, mid_valid_q && $stable(mid_q), "stalled status was lost")

endmodule

/* sv/rclfp_scale_stage.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rclfp_scale_stage
  import rclfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mid_valid_i,
  output logic             mid_ready_o,
  input  mid_t             mid_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [OUT_W-1:0] m_data_o
);

  logic            out_valid_q;
  status_e         status_q;
  logic [CH_W-1:0] held_q [CHANNELS];
  logic [CH_W-1:0] held_d [CHANNELS];
  logic [31:0]     last_q, last_d;
  logic            mid_fire;
  logic            take;

  assign mid_ready_o = !out_valid_q || m_ready_i;
  assign mid_fire    = mid_valid_i && mid_ready_o;
  assign take        = mid_fire && (mid_i.status == ST_OK);
  assign m_valid_o   = out_valid_q;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      held_d[k] = take ? scale_channel(mid_i.raw[k*CH_RAW_W +: CH_RAW_W]) : held_q[k];
    end
    last_d = take ? mid_i.time_us : last_q;
  end

  // Held channels only move when a new status enters the output register,
  // so they stay matched to the status shown while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      last_q      <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        held_q[k] <= '0;
      end
    end else begin
      if (mid_ready_o) begin
        out_valid_q <= mid_valid_i;
      end
      if (mid_fire) begin
        status_q <= mid_i.status;
      end
      last_q <= last_d;
      for (int k = 0; k < CHANNELS; k++) begin
        held_q[k] <= held_d[k];
      end
    end
  end

  always_comb begin
    m_data_o       = '0;
    m_data_o[1:0]  = status_q;
    for (int k = 0; k < CHANNELS; k++) begin
      m_data_o[2 + k*CH_W +: CH_W] = held_q[k];
    end
    m_data_o[2 + CHANNELS*CH_W +: 32] = last_q;
  end

  `ASSERT_NEXT(a_fire_shows, clk_i, rst_ni, mid_fire, out_valid_q, "status lost on its way out")
  `ASSERT_IMPL(a_ok_range, clk_i, rst_ni, out_valid_q && status_q == ST_OK, held_q[0] >= SCALE_OFF && held_q[7] >= SCALE_OFF, "accepted frame shows unscaled channels")
  `ASSERT_NEXT(a_held_stable, clk_i, rst_ni, !take, $stable(last_q) && $stable(held_q[0]), "held values changed without an accepted frame")

endmodule

/* sv/rc_link_frame_parser_top.sv */
`timescale 1ns / 1ps
// RC link frame parser.
// s_axis carries received link bytes: tdata[7:0] is the byte, tdata[39:8] its
// microsecond arrival timestamp. One byte is taken per cycle when tready is high.
// Bytes build a frame (address, length, type, payload, CRC-8). Every completed
// frame gives one request on m_axis: a status and the eight held channel values
// plus the timestamp of the last accepted channel frame. Bytes that do not end
// a frame give nothing.
// A frame's status goes to m_axis through the input register, the frame logic
// and the output register. Throughput is one byte per cycle while they are not
// all full; the CRC and framing update for each byte is combinational.
// When m_axis stalls, the status register holds; the frame stage and the input
// register still fill, and s_axis tready drops only when all three are full.
// Reset clears framing, the held channels, the timestamp and the registers to
// timeout 1750 us, address 0xC8 and type 0x16. The APB port sets those three
// registers at byte addresses 0, 4 and 8; write them only while no frame is
// in flight.
module rc_link_frame_parser_top
  import rclfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,   // rx_byte, arrival_time_us
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // frame_status, channel_a .. channel_h, last_channel_time_us, zero fill
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  rclfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rclfp_byte_stage #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_byte (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_byte_i    (s_axis_tdata[7:0]),
    .s_time_i    (s_axis_tdata[39:8]),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  rclfp_scale_stage u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

/* verif/tb_rc_link_frame_parser_top.sv */
`timescale 1ns / 1ps
module tb_rc_link_frame_parser_top;
  import rclfp_pkg::*;

  localparam int unsigned BUFFER_BYTES = 64;
  localparam int unsigned CH_LSB       = 2;
  localparam int unsigned TIME_LSB     = CH_LSB + CHANNELS * CH_W;
  localparam int unsigned IDLE_WAIT    = 8;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_BYTES = 290;
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct packed {
    status_e                       st;
    logic [CHANNELS-1:0][CH_W-1:0] ch;
    logic [31:0]                   time_us;
  } frame_result_t;

  // Bit-accurate model of the frame parser plus the queue of status requests
  // that the model says must appear on m_axis.
  class rc_frame_predictor;
    logic [15:0]                   timeout_us;
    logic [7:0]                    addr_match;
    logic [7:0]                    type_match;
    logic [7:0]                    frame_mem[BUFFER_BYTES];
    int unsigned                   wr_pos;
    logic [31:0]                   start_us;
    logic [7:0]                    crc_acc;
    logic [CHANNELS-1:0][CH_W-1:0] held;
    logic [31:0]                   accept_us;
    frame_result_t                 expected_q[$];
    int unsigned                   fails;
    int unsigned                   bytes_seen;
    int unsigned                   frames_checked;
    int unsigned                   per_status[3];

    function new();
      timeout_us     = TIMEOUT_RST;
      addr_match     = ADDRESS_RST;
      type_match     = TYPE_RST;
      wr_pos         = 0;
      start_us       = '0;
      crc_acc        = '0;
      held           = '0;
      accept_us      = '0;
      fails          = 0;
      bytes_seen     = 0;
      frames_checked = 0;
      per_status     = '{0, 0, 0};
    endfunction

    static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
      logic [7:0] v;
      v = c ^ d;
      for (int k = 0; k < 8; k++) begin
        v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      end
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TIMEOUT: timeout_us = val[15:0];
        REG_ADDRESS: addr_match = val[7:0];
        REG_TYPE:    type_match = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_TIMEOUT: return {16'h0, timeout_us};
        REG_ADDRESS: return {24'h0, addr_match};
        REG_TYPE:    return {24'h0, type_match};
        default:     return '0;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic [31:0] t);
      int unsigned   idx;
      int unsigned   total;
      int unsigned   bitpos;
      int unsigned   base;
      logic [31:0]   word;
      logic [31:0]   raw;
      frame_result_t r;
      bytes_seen++;
      if ((t - start_us) > 32'(timeout_us)) wr_pos = 0;
      if (wr_pos == 0) start_us = t;
      if (wr_pos >= BUFFER_BYTES) return;
      idx = wr_pos;
      frame_mem[idx] = b;
      wr_pos = idx + 1;
      if (wr_pos <= 2) return;
      total = int'(frame_mem[1]) + 2;
      if (idx == 2) begin
        crc_acc = crc_step(8'h00, b);
      end else if (idx + 2 <= total) begin
        crc_acc = crc_step(crc_acc, b);
      end
      if (wr_pos < total) return;
      wr_pos = 0;
      if (crc_acc != frame_mem[total-1]) begin
        r.st = ST_CRC_BAD;
      end else if (frame_mem[0] == addr_match && frame_mem[2] == type_match) begin
        r.st = ST_OK;
        accept_us = t;
        // Channels are packed LSB first starting at the first payload byte.
        for (int k = 0; k < CHANNELS; k++) begin
          bitpos = k * CH_RAW_W;
          base   = PAYLOAD_FIRST + bitpos / 8;
          word   = {8'h0, frame_mem[base+2], frame_mem[base+1], frame_mem[base]};
          raw    = (word >> (bitpos % 8)) & 32'h7FF;
          held[k] = CH_W'(((raw * 32'd40945) >> 16) + 32'd881);
        end
      end else begin
        r.st = ST_OTHER;
      end
      r.ch      = held;
      r.time_us = accept_us;
      expected_q.push_back(r);
    endfunction

    function void check_status(logic [OUT_W-1:0] d);
      frame_result_t e;
      logic [CH_W-1:0] got;
      if (expected_q.size() == 0) begin
        $error("frame status request on m_axis with none outstanding");
        fails++;
        return;
      end
      e = expected_q.pop_front();
      frames_checked++;
      per_status[e.st]++;
      if (d[1:0] != e.st) begin
        $error("frame_status: expected %0d, got %0d", e.st, d[1:0]);
        fails++;
      end
      for (int k = 0; k < CHANNELS; k++) begin
        got = d[CH_LSB + CH_W*k +: CH_W];
        if (got != e.ch[k]) begin
          $error("channel_%c: expected %0d, got %0d", 8'h61 + k, e.ch[k], got);
          fails++;
        end
      end
      if (d[TIME_LSB +: 32] != e.time_us) begin
        $error("last_channel_time_us: expected %0d, got %0d", e.time_us, d[TIME_LSB +: 32]);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;   // rx_byte, arrival_time_us
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // frame_status, channel_a .. channel_h, last_channel_time_us, zero fill
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  rc_frame_predictor pred;
  logic [7:0]        frame_q[$];
  logic [31:0]       cur_time;
  bit                dirty;
  bit                calm;
  bit                hold_long_req;
  int unsigned       n_settings;
  int unsigned       cycles;

  rc_link_frame_parser_top #(.BUFFER_BYTES(BUFFER_BYTES)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) pred.check_status(m_axis_tdata);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result sink: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    int r;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_long_req) begin
        hold_long_req = 1'b0;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        end
      end
    end
  end

  function automatic int src_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    int gap;
    gap = src_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred.note_byte(b, t);
  endtask

  // Waits until every frame status has been returned and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pred.expected_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pred.write_reg(idx, val);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx != REG_SPARE && rd != pred.reg_value(idx)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, pred.reg_value(idx), rd);
      pred.fails++;
    end
  endtask

  task automatic set_phase(input logic [15:0] tmo, input logic [7:0] addr,
                           input logic [7:0] ftype);
    wait_idle();
    cfg_write(REG_TIMEOUT, {16'($urandom()), tmo});
    cfg_write(REG_ADDRESS, {24'($urandom()), addr});
    cfg_write(REG_TYPE, {24'($urandom()), ftype});
    n_settings++;
    cur_time = $urandom();
    dirty = 1'b1;
  endtask

  // Builds address, length, type, payload and CRC into frame_q. A length
  // below two gives only the three header bytes.
  task automatic build_frame(input logic [7:0] addr, input logic [7:0] len,
                             input logic [7:0] ftype, input fill_e fill, input bit bad);
    logic [7:0] crc;
    logic [7:0] d;
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(len);
    frame_q.push_back(ftype);
    if (len >= 2) begin
      crc = rc_frame_predictor::crc_step(8'h00, ftype);
      for (int i = 0; i < int'(len) - 2; i++) begin
        case (fill)
          FILL_ZERO: d = 8'h00;
          FILL_ONES: d = 8'hFF;
          default:   d = 8'($urandom());
        endcase
        frame_q.push_back(d);
        crc = rc_frame_predictor::crc_step(crc, d);
      end
      if (bad) crc ^= 8'(1 << $urandom_range(0, 7));
      frame_q.push_back(crc);
    end
  endtask

  // Sends the first cut bytes of frame_q, spread so the whole frame stays
  // inside the timeout. A jump ahead of the timeout restarts framing first.
  task automatic send_seq(input int cut, input bit jump);
    int  n;
    int  span;
    bit  complete;
    n = (cut < frame_q.size()) ? cut : frame_q.size();
    span = int'(pred.timeout_us) / frame_q.size();
    if (jump) cur_time += 32'(pred.timeout_us) + 1 + $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      if (i > 0) cur_time += $urandom_range(0, span);
      send_byte(frame_q[i], cur_time);
    end
    complete = (n == frame_q.size()) && (int'(frame_q[1]) + 2 <= BUFFER_BYTES);
    dirty = !((jump || !dirty) && complete);
  endtask

  function automatic logic [7:0] pick_addr();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom()) : pred.addr_match;
  endfunction

  function automatic logic [7:0] pick_type();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom()) : pred.type_match;
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned target;
    int          r;
    int          cnt;
    target = pred.bytes_seen + n;
    while (pred.bytes_seen < target) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) cur_time = 32'hFFFF_FF00 + $urandom_range(0, 255);
      if (r < 55) begin
        build_frame(pick_addr(), 8'd24, pick_type(), FILL_RANDOM, $urandom_range(0, 9) == 0);
        send_seq(frame_q.size(), dirty || $urandom_range(0, 3) == 0);
      end else if (r < 70) begin
        build_frame($urandom_range(0, 1) ? pred.addr_match : 8'($urandom()),
                    8'($urandom_range(0, 62)),
                    $urandom_range(0, 1) ? pred.type_match : 8'($urandom()),
                    FILL_RANDOM, $urandom_range(0, 4) == 0);
        send_seq(frame_q.size(), dirty || $urandom_range(0, 3) == 0);
      end else if (r < 78) begin
        build_frame(pick_addr(), 8'd24, pick_type(), FILL_RANDOM, 1'b0);
        send_seq($urandom_range(1, 25), dirty);
      end else if (r < 84) begin
        build_frame(pick_addr(), 8'($urandom_range(63, 255)), pick_type(), FILL_RANDOM, 1'b0);
        send_seq(BUFFER_BYTES + $urandom_range(0, 8), dirty);
      end else if (r < 92) begin
        cnt = $urandom_range(1, 8);
        for (int i = 0; i < cnt; i++) begin
          cur_time += $urandom_range(0, 3000);
          send_byte(8'($urandom()), cur_time);
        end
        dirty = 1'b1;
      end else begin
        // A frame that runs straight into whatever is left of the last one.
        build_frame(pick_addr(), 8'd24, pick_type(), FILL_RANDOM, 1'b0);
        send_seq(frame_q.size(), 1'b0);
      end
    end
  endtask

  initial begin
    pred          = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_long_req = 1'b0;
    n_settings    = 0;
    dirty         = 1'b1;
    cur_time      = $urandom();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed cases under the reset settings, written back explicitly.
    set_phase(TIMEOUT_RST, ADDRESS_RST, TYPE_RST);
    // A full channel frame goes first so that every byte a short frame can
    // unpack has been written.
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_ZERO, 1'b0);
    send_seq(frame_q.size(), 1'b1);
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_ONES, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_RANDOM, 1'b1);
    send_seq(frame_q.size(), 1'b0);
    build_frame(8'h00, 8'd24, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    build_frame(ADDRESS_RST, 8'd24, 8'h17, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    // Length bytes of zero and one end the frame at the type byte.
    build_frame(ADDRESS_RST, 8'd0, 8'h00, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    build_frame(ADDRESS_RST, 8'd1, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    // A matching channel frame too short to carry all eight channels.
    build_frame(ADDRESS_RST, 8'd5, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    // A length past the buffer fills it and then drops bytes.
    build_frame(ADDRESS_RST, 8'd70, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(68, 1'b0);
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(10, 1'b1);
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b1);
    // The timestamp wraps in the middle of this frame.
    cur_time = 32'hFFFF_FFE0;
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    build_frame(ADDRESS_RST, 8'd62, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b0);
    // A write past the last register must leave all three untouched.
    wait_idle();
    cfg_write(REG_SPARE, $urandom());
    build_frame(ADDRESS_RST, 8'd24, TYPE_RST, FILL_RANDOM, 1'b0);
    send_seq(frame_q.size(), 1'b1);

    // Hold the sink off while short frames pour in, so the input stalls.
    hold_long_req = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 30; i++) begin
      build_frame(ADDRESS_RST, 8'($urandom_range(0, 1)), 8'($urandom()), FILL_RANDOM, 1'b0);
      send_seq(frame_q.size(), 1'b0);
    end
    calm = 1'b0;
    wait_idle();
    run_random(RANDOM_BYTES);

    set_phase(16'hFFFF, 8'h00, 8'h00);
    calm = 1'b1;
    run_random(100);
    calm = 1'b0;
    run_random(RANDOM_BYTES - 100);

    set_phase(16'h0000, 8'hFF, 8'hFF);
    run_random(RANDOM_BYTES);

    set_phase(16'($urandom_range(100, 4000)), 8'($urandom()), 8'($urandom()));
    run_random(RANDOM_BYTES / 2);
    wait_idle();
    run_random(RANDOM_BYTES / 2);

    set_phase(16'd30000, 8'($urandom()), TYPE_RST);
    calm = 1'b1;
    run_random(100);
    calm = 1'b0;
    run_random(RANDOM_BYTES - 100);

    wait_idle();
    if (pred.expected_q.size() != 0) begin
      $error("%0d frame status requests never arrived", pred.expected_q.size());
      pred.fails++;
    end
    $display("Sent %0d link bytes under %0d register settings; checked %0d frames.",
             pred.bytes_seen, n_settings, pred.frames_checked);
    $display("Frames: %0d accepted, %0d CRC mismatches, %0d other address or type.",
             pred.per_status[ST_OK], pred.per_status[ST_CRC_BAD], pred.per_status[ST_OTHER]);
    if (pred.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
